/* hdl/asob_pkg.sv */
// Shared types, constants and a helper function for the ADC sample to offset BCD block.
// Has no dependencies. Every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps

package asob_pkg;

  localparam int SampleWidth       = 12;
  localparam int SampleBitsDefault = 12;
  localparam int OffsetWidth       = 12;
  localparam logic [OffsetWidth-1:0] OffsetReset = 12'd500;
  localparam int FullScaleMv       = 2500;
  localparam int ProductWidth      = 24;
  localparam int BcdWidth          = 16;
  localparam int AsciiWidth        = 7;
  localparam int InDataWidth       = 16;
  localparam int OutDataWidth      = 40;

  // Result of the scale and offset stage. The magnitude never exceeds 4095.
  typedef struct packed {
    logic [OffsetWidth-1:0] mag;
    logic                   neg;
  } scale_t;

  // Upper-case ASCII hex character of one nibble.
  function automatic logic [AsciiWidth-1:0] hex_char(input logic [3:0] nib);
    logic [AsciiWidth-1:0] base;
    base = (nib < 4'd10) ? 7'd48 : 7'd55;
    return base + {3'b000, nib};
  endfunction

endpackage

/* hdl/adc_sample_to_offset_bcd.sv */
// Top level of the ADC sample to offset BCD block.
// Depends on asob_pkg, asob_scale, asob_bcd and asob_hex.
`timescale 1ns / 1ps

// Each accepted sample word is scaled to millivolts as sample * 2500 / 2^SAMPLE_BITS
// (truncated), the programmed offset is subtracted, and one result word comes out with
// the magnitude as four packed BCD digits, the sign in tuser, and the raw sample as
// three ASCII hex characters. The block takes one word per cycle while the master side
// takes its results. A word passes through the input register and then the result
// register, with the scaling, subtraction and BCD digit compares in the logic between
// them. A stalled master side holds both registers and then tready drops.
// The offset resets to 500 mV and is written over the cfg channel, which is always
// ready; write it only while no word is in flight.
module adc_sample_to_offset_bcd #(
  parameter int SAMPLE_BITS = asob_pkg::SampleBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [asob_pkg::OffsetWidth-1:0]     cfg_data_i,   // offset_mv

  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [asob_pkg::InDataWidth-1:0]     s_axis_tdata_i,  // [11:0] sample, rest zero

  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [15:0] magnitude_bcd, [22:16] hex_high, [29:23] hex_mid, [36:30] hex_low, rest zero
  output logic [asob_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  output logic [0:0]                           m_axis_tuser_o   // [0] is_negative
);

  logic [asob_pkg::OffsetWidth-1:0] offset_q;
  logic [asob_pkg::SampleWidth-1:0] sample_q;
  logic                             in_valid_q;
  logic                             out_valid_q;
  logic                             out_advance;
  logic                             in_accept;

  asob_pkg::scale_t                 scale;
  logic [asob_pkg::BcdWidth-1:0]    bcd;
  logic [asob_pkg::AsciiWidth-1:0]  hex_high;
  logic [asob_pkg::AsciiWidth-1:0]  hex_mid;
  logic [asob_pkg::AsciiWidth-1:0]  hex_low;

  logic [asob_pkg::OutDataWidth-1:0] data_d;
  logic [asob_pkg::OutDataWidth-1:0] data_q;
  logic                              neg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= asob_pkg::OffsetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= cfg_data_i;
    end
  end

  // The result register moves when it is empty or its word is being taken;
  // the input register moves whenever the result register can take its word.
  assign out_advance     = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) sample_q <= s_axis_tdata_i[asob_pkg::SampleWidth-1:0];
  end

  asob_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .sample_i    (sample_q),
    .offset_mv_i (offset_q),
    .result_o    (scale)
  );

  asob_bcd u_bcd (
    .bin_i (scale.mag),
    .bcd_o (bcd)
  );

  asob_hex u_hex (
    .sample_i   (sample_q),
    .hex_high_o (hex_high),
    .hex_mid_o  (hex_mid),
    .hex_low_o  (hex_low)
  );

  assign data_d = {3'b000, hex_low, hex_mid, hex_high, bcd};

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      data_q <= data_d;
      neg_q  <= scale.neg;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = neg_q;

endmodule

/* hdl/asob_scale.sv */
// Scales a raw sample to millivolts and subtracts the programmed offset.
// Depends on asob_pkg for widths, the full-scale constant and scale_t.
`timescale 1ns / 1ps

module asob_scale #(
  parameter int SAMPLE_BITS = asob_pkg::SampleBitsDefault
) (
  input  logic [asob_pkg::SampleWidth-1:0] sample_i,
  input  logic [asob_pkg::OffsetWidth-1:0] offset_mv_i,
  output asob_pkg::scale_t                 result_o
);

  logic [asob_pkg::SampleWidth-1:0]  used;
  logic [asob_pkg::ProductWidth-1:0] product;
  logic [asob_pkg::OffsetWidth-1:0]  mv;

  // Only the low SAMPLE_BITS bits of the sample take part in the scaling.
  always_comb begin
    for (int i = 0; i < asob_pkg::SampleWidth; i++) begin
      used[i] = (i < SAMPLE_BITS) ? sample_i[i] : 1'b0;
    end
  end

  assign product = asob_pkg::ProductWidth'(used)
                 * asob_pkg::ProductWidth'(asob_pkg::FullScaleMv);
  assign mv      = asob_pkg::OffsetWidth'(product >> SAMPLE_BITS);

  always_comb begin
    // An exact match gives zero and counts as not negative.
    result_o.neg = (mv < offset_mv_i);
    result_o.mag = result_o.neg ? (offset_mv_i - mv) : (mv - offset_mv_i);
  end

endmodule

/* hdl/asob_bcd.sv */
// Converts a 12-bit binary magnitude into four packed BCD digits.
// Depends on asob_pkg for widths. Each digit is found by parallel compares.
`timescale 1ns / 1ps

module asob_bcd (
  input  logic [asob_pkg::OffsetWidth-1:0] bin_i,
  output logic [asob_pkg::BcdWidth-1:0]    bcd_o
);

  logic [2:0] thou;
  logic [9:0] rem1;
  logic [3:0] hund;
  logic [6:0] rem2;
  logic [3:0] tens;
  logic [3:0] ones;

  always_comb begin
    thou = '0;
    for (int k = 1; k <= 4; k++) begin
      if (bin_i >= 12'(k * 1000)) thou = 3'(k);
    end
    rem1 = 10'(bin_i - 12'(32'(thou) * 1000));

    hund = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem1 >= 10'(k * 100)) hund = 4'(k);
    end
    rem2 = 7'(rem1 - 10'(32'(hund) * 100));

    tens = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem2 >= 7'(k * 10)) tens = 4'(k);
    end
    ones = 4'(rem2 - 7'(32'(tens) * 10));
  end

  assign bcd_o = {1'b0, thou, hund, tens, ones};

endmodule

/* hdl/asob_hex.sv */
// Turns the three nibbles of a raw 12-bit sample into ASCII hex characters.
// Depends on asob_pkg for the hex_char function and widths.
`timescale 1ns / 1ps

module asob_hex (
  input  logic [asob_pkg::SampleWidth-1:0] sample_i,
  output logic [asob_pkg::AsciiWidth-1:0]  hex_high_o,
  output logic [asob_pkg::AsciiWidth-1:0]  hex_mid_o,
  output logic [asob_pkg::AsciiWidth-1:0]  hex_low_o
);

  assign hex_high_o = asob_pkg::hex_char(sample_i[11:8]);
  assign hex_mid_o  = asob_pkg::hex_char(sample_i[7:4]);
  assign hex_low_o  = asob_pkg::hex_char(sample_i[3:0]);

endmodule
